FILE: rtl/core/bpfs_pkg.sv
`timescale 1ns / 1ps

package bpfs_pkg;

    localparam int POS_W      = 32;
    localparam int NRM_W      = 16;
    localparam int TEX_W      = 8;
    localparam int VEC_W      = POS_W + 1;
    localparam int MAG_W      = 23;
    localparam int SQ_W       = 2 * MAG_W + 2;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int UNIT_SHIFT = 30;
    localparam int UNIT_W     = UNIT_SHIFT + 2;
    localparam int QUO_W      = UNIT_SHIFT + 1;
    localparam int PROD_W     = UNIT_W + NRM_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int DOT_SHIFT  = 28;
    localparam int LAM_W      = 19;
    localparam int POW_W      = 33;
    localparam int FRAC_W     = 16;
    localparam int A_W        = 41;
    localparam int SPLIT_W    = 24;
    localparam int TOT_W      = A_W + LAM_W;
    localparam int OUT_SHIFT  = 32;

    localparam logic [POW_W-1:0] SPEC_ONE = POW_W'(64'h0000_0000_0001_0000);
    localparam logic [POW_W-1:0] SPEC_CAP = POW_W'(64'h0000_0001_0000_0000);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 3'd5;

    typedef logic [2:0][VEC_W-1:0]  t_vec3;
    typedef logic [2:0][UNIT_W-1:0] t_unit3;
    typedef logic [2:0][NRM_W-1:0]  t_nrm3;
    typedef logic [2:0][TEX_W-1:0]  t_rgb3;

endpackage

FILE: rtl/core/bpfs_norm.sv
`timescale 1ns / 1ps

module bpfs_norm #(
    parameter int PAY_W = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  bpfs_pkg::t_vec3       i_vec,
    input  logic [PAY_W-1:0]      i_pay,
    output logic                  o_valid,
    output bpfs_pkg::t_unit3      o_unit,
    output logic [PAY_W-1:0]      o_pay
);
    import bpfs_pkg::*;

    localparam int LEAD_W = $clog2(VEC_W);
    localparam int REM_W  = ROOT_W + 2;
    localparam int SIDE_W = PAY_W + 4 + 3 * MAG_W;
    localparam int DSIDE_W = PAY_W + 4;

    function automatic logic [LEAD_W-1:0] lead_one(input logic [VEC_W-1:0] v);
        logic [LEAD_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (v[i]) pos = LEAD_W'(i);
        end
        return pos;
    endfunction

    // magnitude, sign and leading one
    logic [2:0][VEC_W-1:0] n1_mag;
    logic [VEC_W-1:0]      n1_or;
    logic                  r1_v;
    logic [2:0][VEC_W-1:0] r1_mag;
    logic [2:0]            r1_neg;
    logic [LEAD_W-1:0]     r1_lead;
    logic                  r1_zero;
    logic [PAY_W-1:0]      r1_pay;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n1_mag[c] = i_vec[c][VEC_W-1] ? (~i_vec[c] + VEC_W'(1)) : i_vec[c];
        end
        n1_or = n1_mag[0] | n1_mag[1] | n1_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mag  <= n1_mag;
            for (int c = 0; c < 3; c++) r1_neg[c] <= i_vec[c][VEC_W-1];
            r1_lead <= lead_one(n1_or);
            r1_zero <= (n1_or == '0);
            r1_pay  <= i_pay;
        end
    end

    // scale into [2^22, 2^23)
    logic [2:0][VEC_W-1:0] n2_full;
    logic [2:0][MAG_W-1:0] r2_mag;
    logic                  r2_v;
    logic [2:0]            r2_neg;
    logic                  r2_zero;
    logic [PAY_W-1:0]      r2_pay;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r1_lead > LEAD_W'(MAG_W - 1)) begin
                n2_full[c] = r1_mag[c] >> (r1_lead - LEAD_W'(MAG_W - 1));
            end else begin
                n2_full[c] = r1_mag[c] << (LEAD_W'(MAG_W - 1) - r1_lead);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) r2_mag[c] <= n2_full[c][MAG_W-1:0];
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
            r2_pay  <= r1_pay;
        end
    end

    // squares
    logic [2:0][2*MAG_W-1:0] r3_sq;
    logic [2:0][MAG_W-1:0]   r3_mag;
    logic                    r3_v;
    logic [2:0]              r3_neg;
    logic                    r3_zero;
    logic [PAY_W-1:0]        r3_pay;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r3_sq[c] <= (2 * MAG_W)'(r2_mag[c]) * (2 * MAG_W)'(r2_mag[c]);
            end
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
            r3_pay  <= r2_pay;
        end
    end

    // integer square root, one result bit per stage
    logic [SQ_W-1:0]   r_sr_x    [ROOT_W+1];
    logic [REM_W-1:0]  r_sr_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_sr_root [ROOT_W+1];
    logic [SIDE_W-1:0] r_sr_side [ROOT_W+1];
    logic              r_sr_v    [ROOT_W+1];
    logic [REM_W-1:0]  n_sr_rem  [ROOT_W];
    logic [ROOT_W-1:0] n_sr_root [ROOT_W];

    always_comb begin
        logic [REM_W+1:0] sr_sh;
        logic [REM_W+1:0] sr_tr;
        for (int k = 0; k < ROOT_W; k++) begin
            sr_sh = {r_sr_rem[k], r_sr_x[k][SQ_W-1 -: 2]};
            sr_tr = (REM_W + 2)'({r_sr_root[k], 2'b01});
            if (sr_sh >= sr_tr) begin
                n_sr_rem[k]  = REM_W'(sr_sh - sr_tr);
                n_sr_root[k] = {r_sr_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_sr_rem[k]  = REM_W'(sr_sh);
                n_sr_root[k] = {r_sr_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr_x[0]    <= SQ_W'(r3_sq[0]) + SQ_W'(r3_sq[1]) + SQ_W'(r3_sq[2]);
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
            r_sr_side[0] <= {r3_pay, r3_zero, r3_neg, r3_mag};
            for (int k = 0; k < ROOT_W; k++) begin
                r_sr_x[k+1]    <= r_sr_x[k] << 2;
                r_sr_rem[k+1]  <= n_sr_rem[k];
                r_sr_root[k+1] <= n_sr_root[k];
                r_sr_side[k+1] <= r_sr_side[k];
            end
        end
    end

    // restoring division, one quotient bit per stage
    logic [2:0][MAG_W-1:0]  w_fin_mag;
    logic [DSIDE_W-1:0]     w_fin_side;
    logic [2:0][ROOT_W-1:0] r_dv_rem  [QUO_W+1];
    logic [2:0][QUO_W-1:0]  r_dv_quo  [QUO_W+1];
    logic [ROOT_W-1:0]      r_dv_len  [QUO_W+1];
    logic [DSIDE_W-1:0]     r_dv_side [QUO_W+1];
    logic                   r_dv_v    [QUO_W+1];
    logic [2:0]             r_dv_b0;
    logic [2:0][ROOT_W-1:0] n_dv_rem  [QUO_W];
    logic [2:0][QUO_W-1:0]  n_dv_quo  [QUO_W];

    assign w_fin_mag  = r_sr_side[ROOT_W][3*MAG_W-1:0];
    assign w_fin_side = r_sr_side[ROOT_W][SIDE_W-1:3*MAG_W];

    always_comb begin
        logic [ROOT_W:0] dv_sh;
        logic            dv_ge;
        for (int k = 0; k < QUO_W; k++) begin
            for (int c = 0; c < 3; c++) begin
                dv_sh = {r_dv_rem[k][c], (k == 0) ? r_dv_b0[c] : 1'b0};
                dv_ge = (dv_sh >= {1'b0, r_dv_len[k]});
                n_dv_rem[k][c] = dv_ge ? ROOT_W'(dv_sh - {1'b0, r_dv_len[k]})
                                       : dv_sh[ROOT_W-1:0];
                n_dv_quo[k][c] = {r_dv_quo[k][c][QUO_W-2:0], dv_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_dv_rem[0][c] <= ROOT_W'(w_fin_mag[c] >> 1);
                r_dv_b0[c]     <= w_fin_mag[c][0];
            end
            r_dv_quo[0]  <= '0;
            r_dv_len[0]  <= r_sr_root[ROOT_W];
            r_dv_side[0] <= w_fin_side;
            for (int k = 0; k < QUO_W; k++) begin
                r_dv_rem[k+1]  <= n_dv_rem[k];
                r_dv_quo[k+1]  <= n_dv_quo[k];
                r_dv_len[k+1]  <= r_dv_len[k];
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end
    end

    // apply sign, zero vector stays zero
    logic [2:0]        w_out_neg;
    logic              w_out_zero;
    logic              r_o_v;
    t_unit3            r_o_unit;
    logic [PAY_W-1:0]  r_o_pay;

    assign w_out_neg  = r_dv_side[QUO_W][2:0];
    assign w_out_zero = r_dv_side[QUO_W][3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (w_out_zero) begin
                    r_o_unit[c] <= '0;
                end else if (w_out_neg[c]) begin
                    r_o_unit[c] <= UNIT_W'(0) - UNIT_W'(r_dv_quo[QUO_W][c]);
                end else begin
                    r_o_unit[c] <= UNIT_W'(r_dv_quo[QUO_W][c]);
                end
            end
            r_o_pay <= r_dv_side[QUO_W][DSIDE_W-1:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r_o_v <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++) r_sr_v[k] <= 1'b0;
            for (int k = 0; k <= QUO_W; k++) r_dv_v[k] <= 1'b0;
        end else if (i_en) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r_sr_v[0] <= r3_v;
            for (int k = 0; k < ROOT_W; k++) r_sr_v[k+1] <= r_sr_v[k];
            r_dv_v[0] <= r_sr_v[ROOT_W];
            for (int k = 0; k < QUO_W; k++) r_dv_v[k+1] <= r_dv_v[k];
            r_o_v     <= r_dv_v[QUO_W];
        end
    end

    assign o_valid = r_o_v;
    assign o_unit  = r_o_unit;
    assign o_pay   = r_o_pay;

endmodule

FILE: rtl/core/bpfs_pow.sv
`timescale 1ns / 1ps

module bpfs_pow #(
    parameter int EXP   = 50,
    parameter int PAY_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bpfs_pkg::LAM_W-1:0]    i_base,
    input  logic [PAY_W-1:0]              i_pay,
    output logic                          o_valid,
    output logic [bpfs_pkg::POW_W-1:0]    o_pow,
    output logic [PAY_W-1:0]              o_pay
);
    import bpfs_pkg::*;

    localparam int MUL_W = POW_W + LAM_W;

    logic [POW_W-1:0] r_p   [EXP+1];
    logic [LAM_W-1:0] r_s   [EXP+1];
    logic [PAY_W-1:0] r_pay [EXP+1];
    logic             r_v   [EXP+1];
    logic [POW_W-1:0] n_p   [EXP];

    always_comb begin
        logic [MUL_W-1:0] prod;
        logic [MUL_W-1:0] shr;
        for (int k = 0; k < EXP; k++) begin
            prod = MUL_W'(r_p[k]) * MUL_W'(r_s[k]);
            shr  = prod >> FRAC_W;
            n_p[k] = (shr > MUL_W'(SPEC_CAP)) ? SPEC_CAP : shr[POW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0]   <= SPEC_ONE;
            r_s[0]   <= i_base;
            r_pay[0] <= i_pay;
            for (int k = 0; k < EXP; k++) begin
                r_p[k+1]   <= n_p[k];
                r_s[k+1]   <= r_s[k];
                r_pay[k+1] <= r_pay[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= EXP; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < EXP; k++) r_v[k+1] <= r_v[k];
        end
    end

    assign o_valid = r_v[EXP];
    assign o_pow   = r_p[EXP];
    assign o_pay   = r_pay[EXP];

endmodule

FILE: rtl/core/blinn_phong_fragment_shader.sv
`timescale 1ns / 1ps

// Blinn-Phong fragment shader, one fragment per transfer.
// Slave stream: one fragment per transfer (world position, normal, texel).
// Master stream: one shaded RGB result per fragment, in input order.
// Configuration: write light and camera positions through i_cfg_wr_en,
// i_cfg_idx and i_cfg_data while no fragment is in flight; indexes 0..2
// are the light x/y/z, 3..5 the camera x/y/z, others are ignored.
// The pipeline depth comes from two vector normalizers in series, each 61
// stages (24 square-root stages, 31 divider stages), and one multiply
// stage per unit of the specular exponent. One fragment is taken every
// cycle unless the pipeline holds. Reset clears the light and camera
// registers to zero and empties the pipeline. When the receiver holds
// tready low with a result waiting, the whole pipeline holds and
// o_s_axis_tready drops; nothing is lost.
module blinn_phong_fragment_shader #(
    parameter int SPECULAR_EXPONENT = 50
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bpfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bpfs_pkg::POS_W-1:0]        i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // world_x, world_y, world_z, normal_x, normal_y, normal_z,
    // texel_red, texel_green, texel_blue
    input  logic [167:0]                      i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0]                       o_m_axis_tdata
);
    import bpfs_pkg::*;

    localparam int NPAY_W = 3 * NRM_W;
    localparam int TPAY_W = 3 * TEX_W;
    localparam int HPAY_W = LAM_W + TPAY_W + NPAY_W;
    localparam int PPAY_W = LAM_W + TPAY_W;

    logic [2:0][POS_W-1:0] r_light;
    logic [2:0][POS_W-1:0] r_cam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light <= '0;
            r_cam   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_LIGHT_X:  r_light[0] <= i_cfg_data;
                CFG_LIGHT_Y:  r_light[1] <= i_cfg_data;
                CFG_LIGHT_Z:  r_light[2] <= i_cfg_data;
                CFG_CAMERA_X: r_cam[0]   <= i_cfg_data;
                CFG_CAMERA_Y: r_cam[1]   <= i_cfg_data;
                CFG_CAMERA_Z: r_cam[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_v;

    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    logic [2:0][POS_W-1:0] w_world;
    t_nrm3                 w_nrm_in;
    t_rgb3                 w_tex_in;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_world[c]  = i_s_axis_tdata[c*POS_W +: POS_W];
            w_nrm_in[c] = i_s_axis_tdata[3*POS_W + c*NRM_W +: NRM_W];
            w_tex_in[c] = i_s_axis_tdata[3*POS_W + 3*NRM_W + c*TEX_W +: TEX_W];
        end
    end

    // direction vectors to light and camera
    logic  r_d_v;
    t_vec3 r_d_dl;
    t_vec3 r_d_de;
    t_nrm3 r_d_nrm;
    t_rgb3 r_d_tex;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_d_dl[c] <= VEC_W'($signed(r_light[c])) - VEC_W'($signed(w_world[c]));
                r_d_de[c] <= VEC_W'($signed(r_cam[c])) - VEC_W'($signed(w_world[c]));
            end
            r_d_nrm <= w_nrm_in;
            r_d_tex <= w_tex_in;
        end
    end

    logic              w_l_v;
    logic              w_e_v;
    t_unit3            w_lu;
    t_unit3            w_eu;
    logic [NPAY_W-1:0] w_l_pay;
    logic [TPAY_W-1:0] w_e_pay;

    bpfs_norm #(.PAY_W(NPAY_W)) u_norm_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_vec   (r_d_dl),
        .i_pay   (r_d_nrm),
        .o_valid (w_l_v),
        .o_unit  (w_lu),
        .o_pay   (w_l_pay)
    );

    bpfs_norm #(.PAY_W(TPAY_W)) u_norm_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_d_v),
        .i_vec   (r_d_de),
        .i_pay   (r_d_tex),
        .o_valid (w_e_v),
        .o_unit  (w_eu),
        .o_pay   (w_e_pay)
    );

    // half vector sum and lambert products
    t_nrm3                          w_l_nrm;
    logic                           r_a_v;
    t_vec3                          r_a_hs;
    logic signed [2:0][PROD_W-1:0]  r_a_prod;
    t_nrm3                          r_a_nrm;
    t_rgb3                          r_a_tex;

    assign w_l_nrm = w_l_pay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_a_hs[c]   <= VEC_W'($signed(w_lu[c])) + VEC_W'($signed(w_eu[c]));
                r_a_prod[c] <= PROD_W'($signed(w_lu[c])) * PROD_W'($signed(w_l_nrm[c]));
            end
            r_a_nrm <= w_l_nrm;
            r_a_tex <= w_e_pay;
        end
    end

    logic signed [DOT_W-1:0] w_a_dot;
    logic                    r_b_v;
    t_vec3                   r_b_hs;
    logic [LAM_W-1:0]        r_b_lam;
    t_nrm3                   r_b_nrm;
    t_rgb3                   r_b_tex;

    assign w_a_dot = DOT_W'($signed(r_a_prod[0])) + DOT_W'($signed(r_a_prod[1]))
                   + DOT_W'($signed(r_a_prod[2]));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_hs  <= r_a_hs;
            r_b_lam <= (w_a_dot > 0) ? w_a_dot[DOT_SHIFT +: LAM_W] : '0;
            r_b_nrm <= r_a_nrm;
            r_b_tex <= r_a_tex;
        end
    end

    logic              w_h_v;
    t_unit3            w_hu;
    logic [HPAY_W-1:0] w_h_pay;

    bpfs_norm #(.PAY_W(HPAY_W)) u_norm_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_v),
        .i_vec   (r_b_hs),
        .i_pay   ({r_b_lam, r_b_tex, r_b_nrm}),
        .o_valid (w_h_v),
        .o_unit  (w_hu),
        .o_pay   (w_h_pay)
    );

    // specular dot products
    t_nrm3                          w_h_nrm;
    logic                           r_c_v;
    logic signed [2:0][PROD_W-1:0]  r_c_prod;
    logic [PPAY_W-1:0]              r_c_pay;

    assign w_h_nrm = w_h_pay[NPAY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_c_prod[c] <= PROD_W'($signed(w_hu[c])) * PROD_W'($signed(w_h_nrm[c]));
            end
            r_c_pay <= w_h_pay[HPAY_W-1:NPAY_W];
        end
    end

    logic signed [DOT_W-1:0] w_c_dot;
    logic [LAM_W-1:0]        w_c_base;

    assign w_c_dot  = DOT_W'($signed(r_c_prod[0])) + DOT_W'($signed(r_c_prod[1]))
                    + DOT_W'($signed(r_c_prod[2]));
    assign w_c_base = (w_c_dot > 0) ? w_c_dot[DOT_SHIFT +: LAM_W] : '0;

    logic              w_p_v;
    logic [POW_W-1:0]  w_pow;
    logic [PPAY_W-1:0] w_p_pay;

    bpfs_pow #(.EXP(SPECULAR_EXPONENT), .PAY_W(PPAY_W)) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_base  (w_c_base),
        .i_pay   (r_c_pay),
        .o_valid (w_p_v),
        .o_pow   (w_pow),
        .o_pay   (w_p_pay)
    );

    // channel value a = texel + 255 * spec
    t_rgb3                 w_p_tex;
    logic                  r_e_v;
    logic [2:0][A_W-1:0]   r_e_a;
    logic [LAM_W-1:0]      r_e_lam;

    assign w_p_tex = w_p_pay[TPAY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_e_a[c] <= (A_W'(w_p_tex[c]) << FRAC_W) + (A_W'(w_pow) << 8) - A_W'(w_pow);
            end
            r_e_lam <= w_p_pay[PPAY_W-1:TPAY_W];
        end
    end

    // partial products of a * lambert
    localparam int LO_W = SPLIT_W + LAM_W;
    localparam int HI_W = A_W - SPLIT_W + LAM_W;

    logic                 r_f_v;
    logic [2:0][LO_W-1:0] r_f_lo;
    logic [2:0][HI_W-1:0] r_f_hi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_f_lo[c] <= LO_W'(r_e_a[c][SPLIT_W-1:0]) * LO_W'(r_e_lam);
                r_f_hi[c] <= HI_W'(r_e_a[c][A_W-1:SPLIT_W]) * HI_W'(r_e_lam);
            end
        end
    end

    // sum, scale and clamp into the output register
    logic [2:0][TOT_W-1:0] w_tot;
    t_rgb3                 n_out_rgb;
    t_rgb3                 r_out_rgb;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_tot[c] = TOT_W'(r_f_lo[c]) + (TOT_W'(r_f_hi[c]) << SPLIT_W);
            if (|w_tot[c][TOT_W-1:OUT_SHIFT+TEX_W]) begin
                n_out_rgb[c] = '1;
            end else begin
                n_out_rgb[c] = w_tot[c][OUT_SHIFT +: TEX_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_rgb <= n_out_rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v   <= 1'b0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_f_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_d_v   <= i_s_axis_tvalid;
            r_a_v   <= w_l_v & w_e_v;
            r_b_v   <= r_a_v;
            r_c_v   <= w_h_v;
            r_e_v   <= w_p_v;
            r_f_v   <= r_e_v;
            r_out_v <= r_f_v;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_rgb[2], r_out_rgb[1], r_out_rgb[0]};

endmodule
